>>> hw/rtl/cfrs_pkg.sv
// shared types, sizes and codes of the call frame register stack
`default_nettype none

package cfrs_pkg;

  // storage sizes
  localparam int MAX_FRAMES     = 64;
  localparam int PARAM_DEPTH    = 256;
  localparam int REGS_PER_FRAME = 256;

  // derived widths
  localparam int FRAME_W = $clog2(MAX_FRAMES);
  localparam int FCNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int PIDX_W  = $clog2(PARAM_DEPTH);
  localparam int PCNT_W  = $clog2(PARAM_DEPTH + 1);
  localparam int SLOT_W  = $clog2(REGS_PER_FRAME);
  localparam int RADDR_W = FRAME_W + SLOT_W;

  // request kinds
  typedef enum logic [2:0] {
    KIND_PUSH_PARAM = 3'd0,
    KIND_POP_PARAM  = 3'd1,
    KIND_PUSH_FRAME = 3'd2,
    KIND_POP_FRAME  = 3'd3,
    KIND_READ_REG   = 3'd4,
    KIND_WRITE_REG  = 3'd5
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_e;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_FIN
  } state_e;

  // written marks of one frame
  typedef logic [REGS_PER_FRAME-1:0] mark_row_t;

  // controller to datapath commands
  typedef struct packed {
    logic issue;   // request taken, memories read
    logic commit;  // state updated, result loaded
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_valid;
  } dp_stat_t;

  // register number reduced to a slot of the frame, one field per byte value
  typedef logic [256*SLOT_W-1:0] slot_lut_t;

  function automatic slot_lut_t build_slot_lut();
    slot_lut_t lut;
    lut = '0;
    for (int k = 0; k < 256; k++) begin
      lut[k*SLOT_W +: SLOT_W] = SLOT_W'(k % REGS_PER_FRAME);
    end
    return lut;
  endfunction

  localparam slot_lut_t SLOT_LUT = build_slot_lut();

  function automatic logic [SLOT_W-1:0] reg_slot(logic [7:0] idx);
    return SLOT_LUT[int'(idx) * SLOT_W +: SLOT_W];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cfrs_ctrl.sv
// request sequencer of the call frame register stack
`default_nettype none

module cfrs_ctrl
  import cfrs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output cmd_t          cmd_o
);

  state_e state_q, state_d;
  logic   out_free;

  // output register can take a new result
  assign out_free = !stat_i.out_valid || out_ready_i;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.issue  = 1'b0;
    cmd_o.commit = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.issue = in_valid_i;
      end
      S_FIN: begin
        cmd_o.commit = out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/cfrs_datapath.sv
// memories, stack pointers and result register of the call frame register stack
`default_nettype none

module cfrs_datapath
  import cfrs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  input  wire logic [2:0]  kind_i,
  input  wire logic [7:0]  reg_index_i,
  input  wire logic [31:0] value_i,
  input  wire logic [31:0] return_addr_i,
  input  wire logic        out_ready_i,
  output dp_stat_t         stat_o,
  output logic [31:0]      data_o,
  output logic [1:0]       status_o
);

  // storage
  logic [31:0] reg_mem  [2**RADDR_W];
  mark_row_t   mark_mem [MAX_FRAMES];
  logic [31:0] ra_mem   [MAX_FRAMES];
  logic [7:0]  prm_mem  [PARAM_DEPTH];

  // stack pointers and reset-value flags for entry zero
  logic [FCNT_W-1:0] fc_q, fc_d;
  logic [PCNT_W-1:0] pc_q, pc_d;
  logic              ra0_ok_q, ra0_ok_d;
  logic              mark0_ok_q, mark0_ok_d;

  // captured request
  logic [2:0]        kind_q;
  logic [SLOT_W-1:0] slot_q;
  logic [31:0]       value_q;
  logic [31:0]       ra_q;

  // registered read data
  logic [31:0] reg_rd_q;
  mark_row_t   mark_rd_q;
  logic [31:0] ra_rd_q;
  logic [7:0]  prm_rd_q;

  // result register
  logic        out_valid_q;
  logic [31:0] data_q;
  logic [1:0]  status_q;

  // pointer arithmetic
  logic [FCNT_W-1:0]  fc_m1;
  logic [PCNT_W-1:0]  pc_m1;
  logic [FRAME_W-1:0] top_idx;
  logic [FRAME_W-1:0] fc_idx;
  logic [PIDX_W-1:0]  pc_idx;
  logic [PIDX_W-1:0]  pc_m1_idx;
  logic [SLOT_W-1:0]  slot_in;

  assign fc_m1     = fc_q - FCNT_W'(1);
  assign pc_m1     = pc_q - PCNT_W'(1);
  assign top_idx   = fc_m1[FRAME_W-1:0];
  assign fc_idx    = fc_q[FRAME_W-1:0];
  assign pc_idx    = pc_q[PIDX_W-1:0];
  assign pc_m1_idx = pc_m1[PIDX_W-1:0];
  assign slot_in   = reg_slot(reg_index_i);

  // commit-side signals
  logic             no_frame;
  logic             base_top;
  mark_row_t        eff_row;
  logic             reg_we;
  logic             mark_we;
  logic [FRAME_W-1:0] mark_waddr;
  mark_row_t        mark_wdata;
  logic             ra_we;
  logic             prm_we;
  logic [31:0]      res_data;
  logic [1:0]       res_status;

  assign no_frame = (fc_q == '0);
  assign base_top = (fc_q == FCNT_W'(1));
  // row zero reads clear until first written
  assign eff_row  = (base_top && !mark0_ok_q) ? '0 : mark_rd_q;

  // request capture and memory reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      kind_q    <= kind_i;
      slot_q    <= slot_in;
      value_q   <= value_i;
      ra_q      <= return_addr_i;
      reg_rd_q  <= reg_mem[{top_idx, slot_in}];
      mark_rd_q <= mark_mem[top_idx];
      ra_rd_q   <= ra_mem[top_idx];
      prm_rd_q  <= prm_mem[pc_m1_idx];
    end
  end

  // operation decode at commit
  always_comb begin
    fc_d       = fc_q;
    pc_d       = pc_q;
    ra0_ok_d   = ra0_ok_q;
    mark0_ok_d = mark0_ok_q;
    reg_we     = 1'b0;
    mark_we    = 1'b0;
    mark_waddr = top_idx;
    mark_wdata = eff_row | (mark_row_t'(1) << slot_q);
    ra_we      = 1'b0;
    prm_we     = 1'b0;
    res_data   = '0;
    res_status = ST_OK;
    case (kind_q)
      KIND_PUSH_PARAM: begin
        if (pc_q == PCNT_W'(PARAM_DEPTH)) begin
          res_status = ST_OVER;
        end else begin
          prm_we = 1'b1;
          pc_d   = pc_q + PCNT_W'(1);
        end
      end
      KIND_POP_PARAM: begin
        if (pc_q == '0) begin
          res_status = ST_UNDER;
        end else begin
          pc_d     = pc_m1;
          res_data = {{24{prm_rd_q[7]}}, prm_rd_q};
        end
      end
      KIND_PUSH_FRAME: begin
        if (fc_q == FCNT_W'(MAX_FRAMES)) begin
          res_status = ST_OVER;
        end else begin
          ra_we      = 1'b1;
          mark_we    = 1'b1;
          mark_waddr = fc_idx;
          mark_wdata = '0;
          fc_d       = fc_q + FCNT_W'(1);
          if (no_frame) begin
            ra0_ok_d   = 1'b1;
            mark0_ok_d = 1'b1;
          end
        end
      end
      KIND_POP_FRAME: begin
        if (no_frame) begin
          res_status = ST_UNDER;
        end else begin
          fc_d     = fc_m1;
          res_data = (base_top && !ra0_ok_q) ? 32'hFFFF_FFFF : ra_rd_q;
        end
      end
      KIND_READ_REG: begin
        if (no_frame) begin
          res_status = ST_UNDER;
        end else if (eff_row[slot_q]) begin
          res_data = reg_rd_q;
        end
      end
      KIND_WRITE_REG: begin
        if (no_frame) begin
          res_status = ST_UNDER;
        end else begin
          reg_we  = 1'b1;
          mark_we = 1'b1;
          if (base_top) mark0_ok_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // memory writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (reg_we)  reg_mem[{top_idx, slot_q}] <= value_q;
      if (mark_we) mark_mem[mark_waddr]       <= mark_wdata;
      if (ra_we)   ra_mem[fc_idx]             <= ra_q;
      if (prm_we)  prm_mem[pc_idx]            <= value_q[7:0];
    end
  end

  // pointers and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q       <= FCNT_W'(1);
      pc_q       <= '0;
      ra0_ok_q   <= 1'b0;
      mark0_ok_q <= 1'b0;
    end else if (cmd_i.commit) begin
      fc_q       <= fc_d;
      pc_q       <= pc_d;
      ra0_ok_q   <= ra0_ok_d;
      mark0_ok_q <= mark0_ok_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      data_q   <= res_data;
      status_q <= res_status;
    end
  end

  assign stat_o.out_valid = out_valid_q;
  assign data_o           = data_q;
  assign status_o         = status_q;

endmodule

`default_nettype wire

>>> hw/rtl/call_frame_register_stack_top.sv
// top level of the call frame register stack
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, kind_i, reg_index_i,     | request in
//          | value_i, return_addr_i                           |
//  out     | out_valid_o, out_ready_i, data_o, status_o       | result out
//
// each request has an accept step, which reads every memory at the addresses
// given by the stack pointers, and a write-back step, which writes back and
// loads the result register. the next request is taken while a result still
// waits. reset needs no clearing pass: base frame row and return address of
// entry zero read their reset values through two flags. a stalled result
// holds the write-back of the following request until the result is taken.
`default_nettype none

module call_frame_register_stack_top
  import cfrs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [7:0]  reg_index_i,
  input  wire logic [31:0] value_i,
  input  wire logic [31:0] return_addr_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      data_o,
  output logic [1:0]       status_o
);

  cmd_t     cmd;
  dp_stat_t stat;

  // sequencer
  cfrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // storage and result register
  cfrs_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .kind_i        (kind_i),
    .reg_index_i   (reg_index_i),
    .value_i       (value_i),
    .return_addr_i (return_addr_i),
    .out_ready_i   (out_ready_i),
    .stat_o        (stat),
    .data_o        (data_o),
    .status_o      (status_o)
  );

  assign out_valid_o = stat.out_valid;

  // a taken request blocks intake until its write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted on two consecutive cycles");

  // failed operations return zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (data_o == '0))
    else $error("error result with non-zero data");

  // a new result only follows a request in its write-back step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a request in progress");

endmodule

`default_nettype wire

>>> sim/tb_call_frame_register_stack_top.sv
// self-checking testbench for the call frame register stack top level
`timescale 1ns / 1ps

module tb_call_frame_register_stack_top;
  import cfrs_pkg::*;

  // unused kind codes, taken as no operation
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  idx;
    logic [31:0] val;
    logic [31:0] ra;
  } request_t;

  typedef struct packed {
    logic [31:0] data;
    status_e     status;
  } result_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request channel
  logic        in_valid      = 1'b0;
  logic        in_ready_o;
  logic [2:0]  kind_q        = '0;
  logic [7:0]  reg_index_q   = '0;
  logic [31:0] value_q       = '0;
  logic [31:0] return_addr_q = '0;

  // result channel
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [31:0] data_o;
  logic [1:0]  status_o;

  // shadow copy of the frame and parameter stacks
  logic [31:0] bank_data    [MAX_FRAMES*REGS_PER_FRAME];
  bit          bank_written [MAX_FRAMES][REGS_PER_FRAME];
  logic [31:0] frame_ret    [MAX_FRAMES];
  int          frames_live;
  logic [7:0]  param_bytes  [PARAM_DEPTH];
  int          params_live;

  request_t pending_requests [$];
  result_t  expected_results [$];
  request_t cur_req;
  int       total_requests;
  int       requests_taken = 0;
  int       results_seen   = 0;
  int       gap_left       = 0;
  int       stall_left     = 0;
  int       mismatches     = 0;
  int       cycles         = 0;

  call_frame_register_stack_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_q),
    .reg_index_i  (reg_index_q),
    .value_i      (value_q),
    .return_addr_i(return_addr_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .data_o       (data_o),
    .status_o     (status_o)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  // data word with a bias towards the extremes
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // register number, mostly from a few low slots so reads hit writes
  function automatic logic [7:0] pick_slot();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 8'($urandom_range(0, 7));
    if (roll == 6) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic add_request(input logic [2:0] kind, input logic [7:0] idx,
                             input logic [31:0] val, input logic [31:0] ra);
    request_t rq;
    rq.kind = kind;
    rq.idx  = idx;
    rq.val  = val;
    rq.ra   = ra;
    pending_requests.insert(pending_requests.size(), rq);
  endtask

  task automatic add_random(input logic [2:0] kind);
    add_request(kind, pick_slot(), pick_word(), pick_word());
  endtask

  // state after reset: only the base frame, returning to minus one
  task automatic clear_stacks();
    foreach (bank_written[f, s]) bank_written[f][s] = 1'b0;
    foreach (frame_ret[f]) frame_ret[f] = '0;
    frame_ret[0] = 32'hFFFF_FFFF;
    frames_live  = 1;
    params_live  = 0;
  endtask

  // carry out one request on the shadow stacks and give its result
  function automatic result_t apply_request(request_t rq);
    result_t res;
    int      top;
    int      slot;
    logic [7:0] b;
    res.data   = '0;
    res.status = ST_OK;
    slot = int'(rq.idx) % REGS_PER_FRAME;
    case (rq.kind)
      KIND_PUSH_PARAM: begin
        if (params_live >= PARAM_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          param_bytes[params_live] = rq.val[7:0];
          params_live++;
        end
      end
      KIND_POP_PARAM: begin
        if (params_live == 0) begin
          res.status = ST_UNDER;
        end else begin
          params_live--;
          b = param_bytes[params_live];
          res.data = {{24{b[7]}}, b};
        end
      end
      KIND_PUSH_FRAME: begin
        if (frames_live >= MAX_FRAMES) begin
          res.status = ST_OVER;
        end else begin
          frame_ret[frames_live] = rq.ra;
          for (int k = 0; k < REGS_PER_FRAME; k++) bank_written[frames_live][k] = 1'b0;
          frames_live++;
        end
      end
      KIND_POP_FRAME: begin
        if (frames_live == 0) begin
          res.status = ST_UNDER;
        end else begin
          frames_live--;
          res.data = frame_ret[frames_live];
        end
      end
      KIND_READ_REG, KIND_WRITE_REG: begin
        if (frames_live == 0) begin
          res.status = ST_UNDER;
        end else begin
          top = frames_live - 1;
          if (rq.kind == KIND_READ_REG) begin
            if (bank_written[top][slot]) res.data = bank_data[top*REGS_PER_FRAME + slot];
          end else begin
            bank_data[top*REGS_PER_FRAME + slot] = rq.val;
            bank_written[top][slot] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch at cycle %0d, result %0d: %s got %h want %h",
             cycles, results_seen, what, got, want);
  endtask

  // request driver: holds each request until taken, then may idle a while
  always @(posedge clk_i) begin : driver
    logic hold;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      hold = in_valid;
      if (in_valid && in_ready_o) begin
        expected_results.insert(expected_results.size(), apply_request(cur_req));
        requests_taken++;
        hold = 1'b0;
      end
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          cur_req        = pending_requests.pop_front();
          kind_q        <= cur_req.kind;
          reg_index_q   <= cur_req.idx;
          value_q       <= cur_req.val;
          return_addr_q <= cur_req.ra;
          hold = 1'b1;
          // every third stretch of requests runs back to back
          gap_left = ((requests_taken / 80) % 3 == 2) ? 0 : pick_gap();
        end
      end
      in_valid <= hold;
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", data_o, '0);
        end else begin
          want = expected_results.pop_front();
          if (data_o !== want.data) report_mismatch("data", data_o, want.data);
          if (status_o !== want.status) report_mismatch("status", 32'(status_o), 32'(want.status));
        end
      end
      if (stall_left == 0 && (results_seen / 100) % 3 != 1 && $urandom_range(0, 3) == 0)
        stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int roll;
    clear_stacks();

    // directed: underflow on empty parameter stack, reads of unwritten and written registers
    add_request(KIND_POP_PARAM,  8'h00, 32'h0000_0000, 32'h0000_0000);
    add_request(KIND_READ_REG,   8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request(KIND_WRITE_REG,  8'hFF, 32'h7FFF_FFFF, 32'h0000_0000);
    add_request(KIND_READ_REG,   8'hFF, 32'h0000_0000, 32'h0000_0000);
    add_request(KIND_WRITE_REG,  8'h00, 32'h8000_0000, 32'hFFFF_FFFF);
    add_request(KIND_READ_REG,   8'h00, 32'h0000_0000, 32'h0000_0000);
    // parameters keep their low byte and come back sign-extended
    add_request(KIND_PUSH_PARAM, 8'h00, 32'hFFFF_FF80, 32'h0000_0000);
    add_request(KIND_PUSH_PARAM, 8'hFF, 32'h0000_007F, 32'hFFFF_FFFF);
    add_request(KIND_PUSH_PARAM, 8'h00, 32'h1234_5600, 32'h0000_0000);
    add_request(KIND_PUSH_PARAM, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000);
    repeat (4) add_request(KIND_POP_PARAM, 8'h00, 32'h0000_0000, 32'h0000_0000);
    // a fresh frame reads zero, popping returns the stored address
    add_request(KIND_PUSH_FRAME, 8'h00, 32'h0000_0000, 32'h8000_0000);
    add_request(KIND_READ_REG,   8'hFF, 32'h0000_0000, 32'h0000_0000);
    add_request(KIND_POP_FRAME,  8'h00, 32'h0000_0000, 32'h0000_0000);
    // pop the base frame, then everything underflows
    add_request(KIND_POP_FRAME,  8'h00, 32'h0000_0000, 32'h0000_0000);
    add_request(KIND_POP_FRAME,  8'h00, 32'h0000_0000, 32'h0000_0000);
    add_request(KIND_READ_REG,   8'h00, 32'h0000_0000, 32'h0000_0000);
    add_request(KIND_WRITE_REG,  8'h00, 32'h5555_5555, 32'h0000_0000);
    // a new base frame forgets earlier writes
    add_request(KIND_PUSH_FRAME, 8'h00, 32'h0000_0000, 32'h7FFF_FFFF);
    add_request(KIND_READ_REG,   8'h00, 32'h0000_0000, 32'h0000_0000);
    // spare kinds do nothing
    add_request(KIND_SPARE_LO,   8'hA5, 32'hDEAD_BEEF, 32'h0BAD_F00D);
    add_request(KIND_SPARE_HI,   8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // fill the parameter stack past overflow, then take a few back
    repeat (PARAM_DEPTH + 2) add_random(KIND_PUSH_PARAM);
    repeat (20) add_random(KIND_POP_PARAM);

    // nest frames past overflow with some writes, then unwind with some reads
    for (int k = 0; k < MAX_FRAMES + 1; k++) begin
      add_random(KIND_PUSH_FRAME);
      if (k % 8 == 0) add_random(KIND_WRITE_REG);
    end
    for (int k = 0; k < MAX_FRAMES + 2; k++) begin
      add_random(KIND_POP_FRAME);
      if (k % 8 == 5) add_random(KIND_READ_REG);
    end
    add_random(KIND_PUSH_FRAME);

    // mixed traffic
    repeat (60) begin
      roll = $urandom_range(0, 99);
      if      (roll < 15) add_random(KIND_PUSH_PARAM);
      else if (roll < 30) add_random(KIND_POP_PARAM);
      else if (roll < 40) add_random(KIND_PUSH_FRAME);
      else if (roll < 48) add_random(KIND_POP_FRAME);
      else if (roll < 71) add_random(KIND_READ_REG);
      else if (roll < 94) add_random(KIND_WRITE_REG);
      else if (roll < 97) add_random(KIND_SPARE_LO);
      else                add_random(KIND_SPARE_HI);
    end
    total_requests = pending_requests.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_taken != total_requests || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 32'(expected_results.size()), '0);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> call_frame_register_stack_top.f
hw/rtl/cfrs_pkg.sv
hw/rtl/cfrs_ctrl.sv
hw/rtl/cfrs_datapath.sv
hw/rtl/call_frame_register_stack_top.sv
sim/tb_call_frame_register_stack_top.sv
